// ===== rtl/fteg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the fog table entry generator.
package fteg_pkg;

  // Fog modes
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_EXP    = 2'd1;
  localparam logic [1:0] MODE_EXP2   = 2'd2;
  localparam logic [1:0] MODE_RAMP   = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_START   = 2'd1;
  localparam logic [1:0] REG_END     = 2'd2;
  localparam logic [1:0] REG_DENSITY = 2'd3;

  // Reset values
  localparam logic [1:0]  RST_MODE    = MODE_RAMP;
  localparam logic [31:0] RST_START   = 32'd0;
  localparam logic [31:0] RST_END     = 32'h0001_0000;
  localparam logic [31:0] RST_DENSITY = 32'd0;

  // log2(e) and ln(2) in Q.32
  localparam logic [32:0] LOG2E_Q32 = 33'h1_7154_7652;
  localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;

  localparam logic [16:0] ONE_Q16 = 17'h1_0000;

  // Unit latencies in register stages
  localparam int DIV_STEPS = 17;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int TERM_LAT  = 3;
  localparam int TERMS     = 6;   // series terms two to seven
  localparam int EXP_LAT   = 4 + TERMS * TERM_LAT + 1;

  // Sideband that travels alongside each item
  typedef struct packed {
    logic        valid;
    logic [5:0]  idx;
    logic        lin_special;
    logic [16:0] lin_f;
  } fteg_side_t;

endpackage

// ===== rtl/fteg_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider for the linear fog factor, one quotient bit per stage.
module fteg_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [16:0] quot
);
  import fteg_pkg::*;

  logic [48:0] n0;
  logic [31:0] rem_r  [DIV_STEPS+1];
  logic [16:0] low_r  [DIV_STEPS+1];
  logic [16:0] q_r    [DIV_STEPS+1];
  logic [32:0] ext    [DIV_STEPS];
  logic        ge     [DIV_STEPS];
  logic [32:0] diff   [DIV_STEPS];

  // round half up: (num << 16) + den / 2; num < den keeps the quotient in 17 bits
  assign n0 = {1'b0, num, 16'b0} + {18'b0, den[31:1]};

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      ext[j]  = {rem_r[j], low_r[j][16]};
      ge[j]   = ext[j] >= {1'b0, den};
      diff[j] = ext[j] - {1'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n0[48:17];
      low_r[0] <= n0[16:0];
      q_r[0]   <= '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_r[j+1] <= ge[j] ? diff[j][31:0] : ext[j][31:0];
        low_r[j+1] <= {low_r[j][15:0], 1'b0};
        q_r[j+1]   <= {q_r[j][15:0], ge[j]};
      end
    end
  end

  assign quot = q_r[DIV_STEPS];

endmodule

// ===== rtl/fteg_term.sv =====
`timescale 1ns / 1ps
// One series term: t' = trunc(t * h) / K, added to or taken from the running sum.
module fteg_term #(
  parameter int K = 2
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        t_in,
  input  logic [31:0]        h_in,
  input  logic signed [33:0] s_in,
  output logic [31:0]        t_out,
  output logic [31:0]        h_out,
  output logic signed [33:0] s_out
);
  import fteg_pkg::*;

  localparam int          SH    = 34;
  localparam logic [33:0] RECIP = 34'((64'd1 << SH) / K);
  localparam bit          SUBTRACT = (K % 2) == 1;

  logic [63:0]        prod_a;
  logic [31:0]        x_a, h_a;
  logic signed [33:0] s_a;
  logic [65:0]        prod_b;
  logic [31:0]        x_b, q_b, h_b;
  logic signed [33:0] s_b;
  logic [34:0]        back;
  logic [34:0]        rem;
  logic [31:0]        q_c;

  assign prod_a = 64'(t_in) * 64'(h_in);
  assign prod_b = 66'(x_a) * 66'(RECIP);
  // reciprocal estimate is low by at most one
  assign back   = 35'(q_b) * 35'(K);
  assign rem    = {3'b0, x_b} - back;
  assign q_c    = q_b + 32'(rem >= 35'(K));

  always_ff @(posedge clk) begin
    if (en) begin
      x_a   <= prod_a[63:32];
      h_a   <= h_in;
      s_a   <= s_in;
      x_b   <= x_a;
      q_b   <= prod_b[SH+31:SH];
      h_b   <= h_a;
      s_b   <= s_a;
      t_out <= q_c;
      h_out <= h_b;
      s_out <= SUBTRACT ? s_b - $signed({2'b0, q_c}) : s_b + $signed({2'b0, q_c});
    end
  end

endmodule

// ===== rtl/fteg_exp.sv =====
`timescale 1ns / 1ps
// e^(-m) for m in Q.24, result Q1.16, as 2^-n times a seven-term series.
module fteg_exp (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] m,
  input  logic        zero,
  output logic [16:0] f
);
  import fteg_pkg::*;

  localparam int NDLY = TERMS * TERM_LAT;

  logic [63:0] prod1;
  logic        zero1, zero2, zero3, zero4;
  logic [39:0] y;
  logic [7:0]  n2, n3, n4;
  logic [31:0] g2, h3;
  logic [63:0] hp;

  logic [31:0]        t_c [TERMS+1];
  logic [31:0]        h_c [TERMS+1];
  logic signed [33:0] s_c [TERMS+1];

  logic [7:0] n_d    [NDLY];
  logic       zero_d [NDLY];

  logic [32:0] s_pos;
  logic [5:0]  sh;
  logic [40:0] rnd;
  logic [40:0] r;

  assign y  = 40'((prod1 + 64'h80_0000) >> 24);
  assign hp = 64'(g2) * 64'(LN2_Q32);

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= 64'(m) * 64'(LOG2E_Q32);
      zero1 <= zero;
      n2    <= y[39:32];
      g2    <= y[31:0];
      zero2 <= zero1;
      h3    <= hp[63:32];
      n3    <= n2;
      zero3 <= zero2;
      // first term: 1 - h
      t_c[0] <= h3;
      h_c[0] <= h3;
      s_c[0] <= 34'sh1_0000_0000 - $signed({2'b0, h3});
      n4     <= n3;
      zero4  <= zero3;
      n_d[0]    <= n4;
      zero_d[0] <= zero4;
      for (int j = 1; j < NDLY; j++) begin
        n_d[j]    <= n_d[j-1];
        zero_d[j] <= zero_d[j-1];
      end
    end
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    fteg_term #(.K(k + 2)) u_term (
      .clk   (clk),
      .en    (en),
      .t_in  (t_c[k]),
      .h_in  (h_c[k]),
      .s_in  (s_c[k]),
      .t_out (t_c[k+1]),
      .h_out (h_c[k+1]),
      .s_out (s_c[k+1])
    );
  end

  // scale by 2^-(n+16) with rounding
  assign s_pos = s_c[TERMS][33] ? 33'd0 : s_c[TERMS][32:0];
  assign sh    = {1'b0, n_d[NDLY-1][4:0]} + 6'd16;
  assign rnd   = {8'b0, s_pos} + (41'd1 << (sh - 6'd1));
  assign r     = rnd >> sh;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_d[NDLY-1] || n_d[NDLY-1] >= 8'd24) begin
        f <= '0;
      end else if (r > 41'(ONE_Q16)) begin
        f <= ONE_Q16;
      end else begin
        f <= r[16:0];
      end
    end
  end

endmodule

// ===== rtl/fog_table_entry_generator.sv =====
`timescale 1ns / 1ps
// Top level of the fog table entry generator.
//
// Input channel: entry_valid / entry_stall with entry_index. A transfer
// takes place on a rising edge with entry_valid high and entry_stall low.
// Output channel: result_valid / result_stall with entry_number (echo of
// the index) and fog_value (255 = full fog), one result per entry.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
//
// Throughput: one entry per cycle while the pipeline is not held. The
// pipeline length from input transfer to result_valid is set by the
// exponential path (log2 multiply, ln2 multiply, six series terms of
// three stages each, final scaling). The linear divider (one quotient
// bit per stage) runs alongside and is delayed to line up with it.
// The whole pipeline advances as one; it holds when a result is shown and
// result_stall is high, and then entry_stall is raised.
// Reset (synchronous, rst high) clears all valid bits and loads the
// register defaults: ramp mode, start 0, end 1.0, density 0.
module fog_table_entry_generator #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        entry_valid,
  output logic        entry_stall,
  input  logic [5:0]  entry_index,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [5:0]  entry_number,
  output logic [7:0]  fog_value
);
  import fteg_pkg::*;

  localparam int SBN       = 4 + EXP_LAT;
  localparam int LIN_DELAY = 3 + EXP_LAT - DIV_LAT;

  // configuration
  logic [1:0]  fog_mode;
  logic [31:0] fog_start, fog_end, fog_density;
  logic [31:0] lin_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      fog_mode    <= RST_MODE;
      fog_start   <= RST_START;
      fog_end     <= RST_END;
      fog_density <= RST_DENSITY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    fog_mode    <= cfg_data[1:0];
        REG_START:   fog_start   <= cfg_data;
        REG_END:     fog_end     <= cfg_data;
        REG_DENSITY: fog_density <= cfg_data;
        default: ;
      endcase
    end
  end

  // only meaningful once the config has settled, which it has by the time items flow
  always_ff @(posedge clk) begin
    lin_den <= fog_end - fog_start;
  end

  // depth and ramp tables, worked out at elaboration
  logic [31:0] depth_lut [64];
  logic [7:0]  ramp_lut  [64];

  for (genvar g = 0; g < 64; g++) begin : g_lut
    localparam longint unsigned NUM = 64'd1 << (19 + g / 4);
    localparam longint unsigned DV  = 64'(8 - g % 4);
    localparam longint unsigned WV  = (NUM + DV / 2) / DV;
    localparam longint unsigned RV  =
      (64'(g) * 510 + 64'(TABLE_ENTRIES - 1)) / (2 * 64'(TABLE_ENTRIES - 1));
    assign depth_lut[g] = WV[31:0];
    assign ramp_lut[g]  = (RV > 255) ? 8'd255 : RV[7:0];
  end

  // whole pipe moves together
  logic en;
  assign en          = !result_valid || !result_stall;
  assign entry_stall = !en;

  // stage 1: depth lookup
  logic        v1;
  logic [5:0]  idx1;
  logic [31:0] w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1 <= entry_index;
      w1   <= depth_lut[entry_index];
    end
  end

  // stage 2: density product and linear set-up
  fteg_side_t  sb [SBN];
  fteg_side_t  side2;
  logic [63:0] a2;
  logic [31:0] lin_num, lin_num2;

  always_comb begin
    side2       = '0;
    side2.valid = v1;
    side2.idx   = idx1;
    lin_num     = fog_end - w1;
    if (fog_end > fog_start) begin
      if (w1 >= fog_end) begin
        side2.lin_special = 1'b1;
        side2.lin_f       = '0;
      end else if (lin_num >= lin_den) begin
        side2.lin_special = 1'b1;
        side2.lin_f       = ONE_Q16;
      end
    end else begin
      // end at or below start: hard step at end
      side2.lin_special = 1'b1;
      side2.lin_f       = (w1 < fog_end) ? ONE_Q16 : 17'd0;
    end
  end

  // sideband shift: valid bits cleared at reset, the rest just follows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SBN; j++) begin
        sb[j].valid <= 1'b0;
      end
    end else if (en) begin
      sb[0] <= side2;
      for (int j = 1; j < SBN; j++) begin
        sb[j] <= sb[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2       <= 64'(fog_density) * 64'(w1);
      lin_num2 <= lin_num;
    end
  end

  // stages 3 to 5: exponent argument, squared in exp2 mode
  logic [64:0] a_rnd;
  logic [31:0] m3, m4;
  logic [28:0] b3;
  logic        zero3, zero4, zero5;
  logic [57:0] sq4;
  logic [33:0] mx;
  logic [30:0] m5;

  assign a_rnd = {1'b0, a2} + 65'h8000;
  assign mx    = (fog_mode == MODE_EXP2) ? 34'((sq4 + 58'h80_0000) >> 24) : {2'b0, m4};

  always_ff @(posedge clk) begin
    if (en) begin
      m3    <= a_rnd[47:16];
      b3    <= a_rnd[44:16];
      zero3 <= (fog_mode == MODE_EXP2) ? (a2 >= (64'd1 << 44)) : (a2 >= (64'd1 << 47));
      sq4   <= 58'(b3) * 58'(b3);
      m4    <= m3;
      zero4 <= zero3;
      // beyond 87 the factor is taken as zero
      zero5 <= zero4 || (mx > (34'd87 << 24));
      m5    <= mx[30:0];
    end
  end

  logic [16:0] exp_f;

  fteg_exp u_exp (
    .clk  (clk),
    .en   (en),
    .m    (m5),
    .zero (zero5),
    .f    (exp_f)
  );

  // linear quotient, delayed to meet the exponential result
  logic [16:0] lin_q;
  logic [16:0] lin_d [LIN_DELAY];

  fteg_div u_div (
    .clk  (clk),
    .en   (en),
    .num  (lin_num2),
    .den  (lin_den),
    .quot (lin_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lin_d[0] <= lin_q;
      for (int j = 1; j < LIN_DELAY; j++) begin
        lin_d[j] <= lin_d[j-1];
      end
    end
  end

  // final stage: select factor and convert to a blend byte, or read the ramp table in ramp mode
  fteg_side_t  last;
  logic [16:0] f_sel;
  logic [25:0] blend;
  logic [7:0]  v_next;

  assign last = sb[SBN-1];

  always_comb begin
    case (fog_mode)
      MODE_LINEAR: f_sel = last.lin_special ? last.lin_f : lin_d[LIN_DELAY-1];
      MODE_EXP:    f_sel = exp_f;
      MODE_EXP2:   f_sel = exp_f;
      default:     f_sel = '0;
    endcase
    blend  = 26'(ONE_Q16 - f_sel) * 26'd255 + 26'h8000;
    v_next = (fog_mode == MODE_RAMP) ? ramp_lut[last.idx] : blend[23:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry_number <= last.idx;
      fog_value    <= v_next;
    end
  end

endmodule
